// File: src/cbt_pkg.sv
// Shared constants for the coverage bitmap tracker.
`default_nettype none

package cbt_pkg;

  localparam int FIELD_W = 64;
  localparam int COUNT_W = 20;
  localparam int MODE_W  = 2;

  localparam logic [FIELD_W-1:0] DIGEST_SEED = 64'd5381;

  localparam logic OP_LOG   = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NODES = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PATH  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_PATH;

endpackage

`default_nettype wire

// File: src/cbt_if.sv
// Valid/ready channel interfaces for trace input and result output.
`default_nettype none

interface cbt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [cbt_pkg::FIELD_W-1:0]  block_address;

  modport source (output valid, output opcode, output block_address, input ready);
  modport sink   (input valid, input opcode, input block_address, output ready);
endinterface

interface cbt_out_if;
  logic                         valid;
  logic                         ready;
  logic [cbt_pkg::FIELD_W-1:0]  running_path_hash;
  logic [cbt_pkg::FIELD_W-1:0]  running_set_hash;
  logic [cbt_pkg::COUNT_W-1:0]  new_node_total;
  logic                         first_in_run;
  logic                         first_ever;

  modport source (output valid, output running_path_hash, output running_set_hash,
                  output new_node_total, output first_in_run, output first_ever,
                  input ready);
  modport sink   (input valid, input running_path_hash, input running_set_hash,
                  input new_node_total, input first_in_run, input first_ever,
                  output ready);
endinterface

`default_nettype wire

// File: src/cbt_hash.sv
// Iterative djb2 path fold and node hash / map index unit.
`default_nettype none

module cbt_hash #(
  parameter int ADDR_BITS = 64,
  parameter int MAP_BYTES = 65536
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start_i,
  input  wire logic [ADDR_BITS-1:0]         addr_i,
  input  wire logic [ADDR_BITS-1:0]         seed_i,
  output logic                              busy_o,
  output logic [ADDR_BITS-1:0]              digest_o,
  output logic [ADDR_BITS-1:0]              node_o,
  output logic [$clog2(MAP_BYTES)-1:0]      idx_o
);

  localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
  localparam int FOLD_STEPS = (ADDR_BYTES + 1) / 2;
  localparam int FC_W       = $clog2(FOLD_STEPS) + 1;
  localparam int IDX_BITS   = $clog2(MAP_BYTES);
  localparam bit ODD_BYTES  = (ADDR_BYTES % 2) == 1;
  localparam bit MAP_POW2   = (MAP_BYTES & (MAP_BYTES - 1)) == 0;

  logic [ADDR_BITS-1:0] dig_r, sh_r, node_r, node_in, d1, d2;
  logic [FC_W-1:0]      fcnt_r;
  logic                 fbusy_r, two_ok, mod_busy;

  assign node_in = (addr_i >> 4) ^ (addr_i << 8);

  // two bytes per cycle; an odd byte count leaves one for the last step
  assign two_ok = !(ODD_BYTES && (fcnt_r == FC_W'(FOLD_STEPS - 1)));
  assign d1     = (dig_r << 5) + dig_r + ADDR_BITS'(sh_r[7:0]);
  assign d2     = two_ok ? ((d1 << 5) + d1 + ADDR_BITS'(sh_r[15:8])) : d1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbusy_r <= 1'b0;
      fcnt_r  <= '0;
    end else if (start_i) begin
      fbusy_r <= 1'b1;
      fcnt_r  <= '0;
    end else if (fbusy_r) begin
      fcnt_r <= fcnt_r + FC_W'(1);
      if (fcnt_r == FC_W'(FOLD_STEPS - 1)) fbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dig_r  <= seed_i;
      sh_r   <= addr_i;
      node_r <= node_in;
    end else if (fbusy_r) begin
      dig_r <= d2;
      sh_r  <= sh_r >> 16;
    end
  end

  generate
    if (MAP_POW2) begin : g_mask
      logic [IDX_BITS-1:0] idx_r;
      always_ff @(posedge clk) begin
        if (start_i) idx_r <= node_in[IDX_BITS+2:3];
      end
      assign idx_o    = idx_r;
      assign mod_busy = 1'b0;
    end else begin : g_mod
      // fold 16-bit digits by 2^(16i) mod MAP_BYTES, then an exact
      // reciprocal multiply and subtract, registered in sum_r, q_r and rem_r
      localparam int QB    = ADDR_BITS - 3;
      localparam int ND    = (QB + 15) / 16;
      localparam int QPAD  = ND * 16;
      localparam int SUM_W = IDX_BITS + 18;
      localparam int R_W   = SUM_W + 2;
      localparam int P_W   = SUM_W + R_W;
      localparam int Q_W   = SUM_W - IDX_BITS + 1;
      localparam int SHIFT = SUM_W + IDX_BITS;
      localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(MAP_BYTES) - 64'd1) / 64'(MAP_BYTES);
      logic [QPAD-1:0]     x_r;
      logic [SUM_W-1:0]    part [ND];
      logic [SUM_W-1:0]    sum_c, sum_r, qm;
      logic [P_W-1:0]      prod;
      logic [Q_W-1:0]      q_r;
      logic [IDX_BITS-1:0] rem_r;
      logic [2:0]          mph_r;

      for (genvar g = 0; g < ND; g++) begin : g_part
        localparam logic [63:0] RES = (64'd1 << (16 * g)) % 64'(MAP_BYTES);
        assign part[g] = SUM_W'(x_r[16*g +: 16]) * SUM_W'(RES);
      end

      always_comb begin
        sum_c = '0;
        for (int j = 0; j < ND; j++) sum_c = sum_c + part[j];
      end

      assign prod = P_W'(sum_r) * P_W'(R_W'(RECIP));
      assign qm   = SUM_W'(q_r) * SUM_W'(MAP_BYTES);

      always_ff @(posedge clk) begin
        if (!rst_n) mph_r <= '0;
        else if (start_i) mph_r <= 3'b001;
        else mph_r <= mph_r << 1;
      end

      always_ff @(posedge clk) begin
        if (start_i) x_r <= QPAD'(node_in[ADDR_BITS-1:3]);
        if (mph_r[0]) sum_r <= sum_c;
        if (mph_r[1]) q_r <= prod[SHIFT +: Q_W];
        if (mph_r[2]) rem_r <= IDX_BITS'(sum_r - qm);
      end

      assign idx_o    = rem_r;
      assign mod_busy = |mph_r;
    end
  endgenerate

  assign busy_o   = fbusy_r | mod_busy;
  assign digest_o = dig_r;
  assign node_o   = node_r;

endmodule

`default_nettype wire

// File: src/coverage_bitmap_tracker_top.sv
// Top level: run and lifetime coverage maps, digests and result register.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        opcode, block_address
//  out_ch   out  valid/ready        path hash, set hash, new-node total, flags
//  cfg_*    in   cfg_we (no wait)   cfg_wdata = track_mode
//
// A logged address is hashed by the two-bytes-a-cycle djb2 fold; a non
// power-of-two map also runs a remainder unit, and the hash stays busy until
// both are done. A start op sweeps the run map clear, then emits a result beat.
// After reset both maps are swept clear with in_ch.ready low. One result beat
// may wait in the output register while the next item is worked on.
`default_nettype none

module coverage_bitmap_tracker_top #(
  parameter int MAP_BYTES = 65536,
  parameter int ADDR_BITS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cbt_in_if.sink                           in_ch,
  cbt_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [cbt_pkg::MODE_W-1:0]  cfg_wdata
);

  localparam int IDX_BITS = $clog2(MAP_BYTES);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_UPD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_BITS-1:0]          clr_idx_r, clr_idx_nxt, wr_idx, hash_idx;
  logic                         clr_life_r, clr_life_nxt;
  logic [ADDR_BITS-1:0]         path_r, path_nxt, set_r, set_nxt;
  logic [ADDR_BITS-1:0]         hash_dig, hash_node;
  logic [cbt_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cbt_pkg::MODE_W-1:0]   mode_r;

  logic                         ov_r, ov_nxt;
  logic [ADDR_BITS-1:0]         o_path_r, o_path_nxt, o_set_r, o_set_nxt;
  logic [cbt_pkg::COUNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic                         o_fir_r, o_fir_nxt, o_fev_r, o_fev_nxt;

  logic                         run_we, life_we, hash_start, hash_busy, in_ready, out_free;
  logic [7:0]                   run_wd, life_wd, run_q, life_q, bmask;
  logic                         tracking;

  logic [7:0] run_mem  [MAP_BYTES];
  logic [7:0] life_mem [MAP_BYTES];

  cbt_hash #(
    .ADDR_BITS (ADDR_BITS),
    .MAP_BYTES (MAP_BYTES)
  ) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (hash_start),
    .addr_i   (in_ch.block_address[ADDR_BITS-1:0]),
    .seed_i   (path_r),
    .busy_o   (hash_busy),
    .digest_o (hash_dig),
    .node_o   (hash_node),
    .idx_o    (hash_idx)
  );

  // index is held by the hash unit, so read data is current in S_UPD
  always_ff @(posedge clk) begin
    if (run_we) run_mem[wr_idx] <= run_wd;
    run_q <= run_mem[hash_idx];
  end

  always_ff @(posedge clk) begin
    if (life_we) life_mem[wr_idx] <= life_wd;
    life_q <= life_mem[hash_idx];
  end

  assign bmask    = 8'b1 << hash_node[2:0];
  assign out_free = !ov_r || out_ch.ready;
  assign tracking = (mode_r == cbt_pkg::MODE_COUNT) || (mode_r == cbt_pkg::MODE_NODES);

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    clr_life_nxt = clr_life_r;
    path_nxt     = path_r;
    set_nxt      = set_r;
    cnt_nxt      = cnt_r;
    ov_nxt       = ov_r && !out_ch.ready;
    o_path_nxt   = o_path_r;
    o_set_nxt    = o_set_r;
    o_cnt_nxt    = o_cnt_r;
    o_fir_nxt    = o_fir_r;
    o_fev_nxt    = o_fev_r;
    run_we       = 1'b0;
    life_we      = 1'b0;
    wr_idx       = clr_idx_r;
    run_wd       = '0;
    life_wd      = '0;
    hash_start   = 1'b0;
    in_ready     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        run_we  = 1'b1;
        life_we = clr_life_r;
        if (clr_idx_r == IDX_BITS'(MAP_BYTES - 1)) begin
          state_nxt    = clr_life_r ? S_IDLE : S_EMIT;
          clr_life_nxt = 1'b0;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_BITS'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.opcode == cbt_pkg::OP_START) begin
            path_nxt    = ADDR_BITS'(cbt_pkg::DIGEST_SEED);
            set_nxt     = ADDR_BITS'(cbt_pkg::DIGEST_SEED);
            cnt_nxt     = '0;
            clr_idx_nxt = '0;
            state_nxt   = S_CLEAR;
          end else begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (!hash_busy) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          path_nxt  = hash_dig;
          o_fir_nxt = 1'b0;
          o_fev_nxt = 1'b0;
          wr_idx    = hash_idx;
          if (tracking && ((run_q & bmask) == 8'h00)) begin
            run_we    = 1'b1;
            run_wd    = run_q | bmask;
            set_nxt   = set_r ^ hash_node;
            o_fir_nxt = 1'b1;
            if ((mode_r == cbt_pkg::MODE_COUNT) && ((life_q & bmask) == 8'h00)) begin
              life_we   = 1'b1;
              life_wd   = life_q | bmask;
              cnt_nxt   = cnt_r + cbt_pkg::COUNT_W'(1);
              o_fev_nxt = 1'b1;
            end
          end
          o_path_nxt = path_nxt;
          o_set_nxt  = set_nxt;
          o_cnt_nxt  = cnt_nxt;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          o_path_nxt = path_r;
          o_set_nxt  = set_r;
          o_cnt_nxt  = cnt_r;
          o_fir_nxt  = 1'b0;
          o_fev_nxt  = 1'b0;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_idx_r  <= '0;
      clr_life_r <= 1'b1;
      path_r     <= ADDR_BITS'(cbt_pkg::DIGEST_SEED);
      set_r      <= ADDR_BITS'(cbt_pkg::DIGEST_SEED);
      cnt_r      <= '0;
      mode_r     <= cbt_pkg::MODE_RESET;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_life_r <= clr_life_nxt;
      path_r     <= path_nxt;
      set_r      <= set_nxt;
      cnt_r      <= cnt_nxt;
      ov_r       <= ov_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    o_path_r <= o_path_nxt;
    o_set_r  <= o_set_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_fir_r  <= o_fir_nxt;
    o_fev_r  <= o_fev_nxt;
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = ov_r;
  assign out_ch.running_path_hash = cbt_pkg::FIELD_W'(o_path_r);
  assign out_ch.running_set_hash  = cbt_pkg::FIELD_W'(o_set_r);
  assign out_ch.new_node_total    = o_cnt_r;
  assign out_ch.first_in_run      = o_fir_r;
  assign out_ch.first_ever        = o_fev_r;

endmodule

`default_nettype wire
